[rtl/greedy_box_nms_unit_macros.svh]
// Assertion macros shared by the greedy box suppression RTL
`ifndef GREEDY_BOX_NMS_UNIT_MACROS_SVH
`define GREEDY_BOX_NMS_UNIT_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gbn_pkg.sv]
// Types and constants for the greedy box suppression unit
`default_nettype none

package gbn_pkg;

    localparam int IOU_STAGES = 6;

    localparam logic [6:0]  RESULT_CAP    = 7'd64;
    localparam logic [15:0] THRESH_RESET  = 16'd19661;
    localparam logic [6:0]  MAXPICK_RESET = 7'd2;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_PICKS = 1'b1;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_geo;

    typedef struct packed {
        logic        valid;
        logic        supp;
        t_geo        geo;
        logic [15:0] score;
    } t_slot;

    typedef struct packed {
        logic adv;
        logic clr_valid;
        logic clr_supp;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/gbn_if.sv]
// Channel interfaces: box input, pick output, register write
`default_nettype none

interface gbn_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        score;
    logic               last_box;

    modport source (output valid, center_x, center_y, box_width, box_height, score,
                    last_box, input ready);
    modport sink   (input valid, center_x, center_y, box_width, box_height, score,
                    last_box, output ready);
endinterface

interface gbn_pick_if;
    logic       valid;
    logic       ready;
    logic [5:0] picked_index;
    logic       last_pick;

    modport source (output valid, picked_index, last_pick, input ready);
    modport sink   (input valid, picked_index, last_pick, output ready);
endinterface

interface gbn_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/gbn_cell.sv]
// One ring cell: holds a box with its score, valid and suppressed flags
`default_nettype none

module gbn_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gbn_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_load,
    input  wire gbn_pkg::t_geo     i_load_geo,
    input  wire logic [15:0]       i_load_score,
    input  wire gbn_pkg::t_slot    i_prev,
    output gbn_pkg::t_slot         o_slot
);

    logic          r_valid;
    logic          r_supp;
    gbn_pkg::t_geo r_geo;
    logic [15:0]   r_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_supp  <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_supp  <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_prev.valid;
            r_supp  <= i_prev.supp;
        end else begin
            if (i_ctl.clr_valid) r_valid <= 1'b0;
            if (i_ctl.clr_supp)  r_supp  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_geo   <= i_load_geo;
            r_score <= i_load_score;
        end else if (i_ctl.adv) begin
            r_geo   <= i_prev.geo;
            r_score <= i_prev.score;
        end
    end

    assign o_slot = '{valid: r_valid, supp: r_supp, geo: r_geo, score: r_score};

endmodule

`default_nettype wire

[rtl/gbn_iou.sv]
// Pipelined overlap test of a travelling box against the current pick
`default_nettype none

module gbn_iou (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic           i_flush,
    input  wire gbn_pkg::t_geo  i_pick,
    input  wire logic [15:0]    i_threshold,
    input  wire gbn_pkg::t_slot i_slot,
    output gbn_pkg::t_slot      o_slot,
    output logic                o_overlap
);

    localparam int NS = gbn_pkg::IOU_STAGES;

    gbn_pkg::t_slot r_slot [NS];

    logic signed [18:0] r1_x1, r1_x2, r1_y1, r1_y2;
    logic [16:0]        r2_iw, r2_ih;
    logic [33:0]        r3_inter;
    logic [31:0]        r3_aa, r3_ab;
    logic [33:0]        r4_inter;
    logic [35:0]        r4_union;
    logic [33:0]        r5_inter;
    logic [51:0]        r5_prod;
    logic               r6_ovl;

    logic signed [18:0] w_alx, w_ahx, w_blx, w_bhx;
    logic signed [18:0] w_aly, w_ahy, w_bly, w_bhy;
    logic signed [19:0] w_dx, w_dy;
    logic [16:0]        w_iw, w_ih;

    always_comb begin
        w_alx = {{2{i_pick.cx[15]}}, i_pick.cx, 1'b0} - {3'b000, i_pick.w};
        w_ahx = {{2{i_pick.cx[15]}}, i_pick.cx, 1'b0} + {3'b000, i_pick.w};
        w_aly = {{2{i_pick.cy[15]}}, i_pick.cy, 1'b0} - {3'b000, i_pick.h};
        w_ahy = {{2{i_pick.cy[15]}}, i_pick.cy, 1'b0} + {3'b000, i_pick.h};
        w_blx = {{2{i_slot.geo.cx[15]}}, i_slot.geo.cx, 1'b0} - {3'b000, i_slot.geo.w};
        w_bhx = {{2{i_slot.geo.cx[15]}}, i_slot.geo.cx, 1'b0} + {3'b000, i_slot.geo.w};
        w_bly = {{2{i_slot.geo.cy[15]}}, i_slot.geo.cy, 1'b0} - {3'b000, i_slot.geo.h};
        w_bhy = {{2{i_slot.geo.cy[15]}}, i_slot.geo.cy, 1'b0} + {3'b000, i_slot.geo.h};
        w_dx  = {r1_x2[18], r1_x2} - {r1_x1[18], r1_x1};
        w_dy  = {r1_y2[18], r1_y2} - {r1_y1[18], r1_y1};
        // overlap extent never exceeds twice the narrower size
        w_iw  = (w_dx[19] || (w_dx == 20'sd0)) ? 17'd0 : w_dx[16:0];
        w_ih  = (w_dy[19] || (w_dy == 20'sd0)) ? 17'd0 : w_dy[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            for (int s = 0; s < NS; s++) r_slot[s].valid <= 1'b0;
        end else if (i_adv) begin
            r_slot[0] <= i_slot;
            for (int s = 1; s < NS; s++) r_slot[s] <= r_slot[s-1];
            r1_x1    <= (w_alx > w_blx) ? w_alx : w_blx;
            r1_x2    <= (w_ahx < w_bhx) ? w_ahx : w_bhx;
            r1_y1    <= (w_aly > w_bly) ? w_aly : w_bly;
            r1_y2    <= (w_ahy < w_bhy) ? w_ahy : w_bhy;
            r2_iw    <= w_iw;
            r2_ih    <= w_ih;
            r3_inter <= 34'(r2_iw) * 34'(r2_ih);
            r3_aa    <= 32'(i_pick.w) * 32'(i_pick.h);
            r3_ab    <= 32'(r_slot[1].geo.w) * 32'(r_slot[1].geo.h);
            r4_inter <= r3_inter;
            r4_union <= 36'({r3_aa, 2'b00}) + 36'({r3_ab, 2'b00}) - 36'(r3_inter);
            r5_inter <= r4_inter;
            r5_prod  <= 52'(i_threshold) * 52'(r4_union);
            r6_ovl   <= {2'b00, r5_inter, 16'h0000} > r5_prod;
        end
    end

    assign o_slot    = r_slot[NS-1];
    assign o_overlap = r6_ovl;

endmodule

`default_nettype wire

[rtl/greedy_box_nms_unit.sv]
// Greedy non-maximum suppression over a rotating ring of box cells
//
//   channel  dir  handshake      payload
//   i_box    in   valid/ready    center_x center_y box_width box_height score last_box
//   o_pick   out  valid/ready    picked_index last_pick
//   i_cfg    in   valid/ready    index data (0 threshold, 1 max picks)
//
// Boxes load one per cycle while the unit is idle. Selection rotates the ring
// once per pass; the six IoU pipeline stages are part of the ring.
// P picks take P passes, plus a closing pass that finds nothing; a set cut
// short by max picks ends instead with a flush state for the final transfer.
// The ring advances only while the output register can take a transfer.
// Reset is synchronous; box storage needs no clearing pass.
`default_nettype none
`include "greedy_box_nms_unit_macros.svh"

module greedy_box_nms_unit #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbn_box_if.sink   i_box,
    gbn_pick_if.source o_pick,
    gbn_cfg_if.sink   i_cfg
);

    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int RING = MAX_BOXES + gbn_pkg::IOU_STAGES;
    localparam int PW   = $clog2(RING);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} t_state;

    t_state r_state;
    logic [15:0]     r_thresh;
    logic [6:0]      r_maxp;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   r_pos;
    logic            r_found;
    logic [15:0]     r_best_score;
    logic [IW-1:0]   r_best_idx;
    gbn_pkg::t_geo   r_best_geo;
    logic            r_pick_v;
    logic [IW-1:0]   r_pick_idx;
    gbn_pkg::t_geo   r_pick_geo;
    logic            r_pend_v;
    logic [6:0]      r_pick_cnt;
    logic            r_out_v;
    logic [5:0]      r_out_idx;
    logic            r_out_last;

    gbn_pkg::t_slot     w_cell [MAX_BOXES];
    gbn_pkg::t_slot     w_exit, w_back;
    gbn_pkg::t_cell_ctl w_ctl;
    gbn_pkg::t_geo      w_load_geo, w_b_geo;
    logic               w_ovl, w_box_acc, w_start, w_out_free, w_adv, w_pass_end;
    logic               w_kill, w_cand, w_found_run, w_take, w_f, w_emit;
    logic [IW-1:0]      w_b_idx;
    logic [6:0]         w_limit;

    assign w_box_acc  = i_box.valid && i_box.ready;
    assign w_start    = w_box_acc && i_box.last_box;
    assign w_out_free = !r_out_v || o_pick.ready;
    assign w_adv      = (r_state == S_RUN) && w_out_free;
    assign w_pass_end = w_adv && (r_pos == PW'(MAX_BOXES - 1));
    assign w_emit     = (w_pass_end && r_pend_v) || ((r_state == S_FLUSH) && w_out_free);

    assign w_load_geo = '{cx: i_box.center_x, cy: i_box.center_y,
                          w: i_box.box_width, h: i_box.box_height};
    assign w_ctl = '{adv: w_adv, clr_valid: w_box_acc && (r_count == '0),
                     clr_supp: w_start};

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        gbn_pkg::t_slot w_prev;
        if (k == MAX_BOXES - 1) begin : g_tail
            assign w_prev = w_back;
        end else begin : g_mid
            assign w_prev = w_cell[k+1];
        end
        gbn_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_load      (w_box_acc && (r_count == CW'(k))),
            .i_load_geo  (w_load_geo),
            .i_load_score(i_box.score),
            .i_prev      (w_prev),
            .o_slot      (w_cell[k])
        );
    end

    gbn_iou u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_flush    (w_start),
        .i_pick     (r_pick_geo),
        .i_threshold(r_thresh),
        .i_slot     (w_cell[0]),
        .o_slot     (w_exit),
        .o_overlap  (w_ovl)
    );

    always_comb begin
        w_kill      = r_pick_v && ((r_pos == PW'(r_pick_idx)) || w_ovl);
        w_back      = w_exit;
        w_back.supp = w_exit.supp || w_kill;
        w_cand      = w_exit.valid && !w_back.supp;
        w_found_run = (r_pos == '0) ? 1'b0 : r_found;
        w_take      = w_cand && (!w_found_run || (w_exit.score > r_best_score));
        w_f         = w_found_run || w_take;
        w_b_idx     = w_take ? r_pos[IW-1:0] : r_best_idx;
        w_b_geo     = w_take ? w_exit.geo : r_best_geo;
        w_limit     = ((r_maxp == 7'd0) || (r_maxp > gbn_pkg::RESULT_CAP))
                      ? gbn_pkg::RESULT_CAP : r_maxp;
    end

    assign i_box.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_pick.valid        = r_out_v;
    assign o_pick.picked_index = r_out_idx;
    assign o_pick.last_pick    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= gbn_pkg::THRESH_RESET;
            r_maxp   <= gbn_pkg::MAXPICK_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gbn_pkg::CFG_THRESHOLD: r_thresh <= i_cfg.data;
                gbn_pkg::CFG_MAX_PICKS: r_maxp   <= i_cfg.data[6:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pos      <= PW'(MAX_BOXES);
            r_found    <= 1'b0;
            r_pick_v   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_pick_cnt <= 7'd0;
            r_out_v    <= 1'b0;
        end else begin
            if (w_emit)            r_out_v <= 1'b1;
            else if (o_pick.ready) r_out_v <= 1'b0;
            if (w_box_acc) begin
                if (i_box.last_box)                r_count <= '0;
                else if (r_count < CW'(MAX_BOXES)) r_count <= r_count + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state    <= S_RUN;
                        r_pos      <= PW'(MAX_BOXES);
                        r_found    <= 1'b0;
                        r_pick_v   <= 1'b0;
                        r_pend_v   <= 1'b0;
                        r_pick_cnt <= 7'd0;
                    end
                end
                S_RUN: begin
                    if (w_adv) begin
                        r_pos   <= (r_pos == PW'(RING - 1)) ? '0 : r_pos + PW'(1);
                        r_found <= w_f;
                        if (w_take) begin
                            r_best_score <= w_exit.score;
                            r_best_idx   <= r_pos[IW-1:0];
                            r_best_geo   <= w_exit.geo;
                        end
                    end
                    if (w_pass_end) begin
                        if (r_pend_v) begin
                            r_out_idx  <= 6'(r_pick_idx);
                            r_out_last <= !w_f;
                        end
                        if (w_f) begin
                            r_pend_v   <= 1'b1;
                            r_pick_v   <= 1'b1;
                            r_pick_idx <= w_b_idx;
                            r_pick_geo <= w_b_geo;
                            r_pick_cnt <= r_pick_cnt + 7'd1;
                            if ((r_pick_cnt + 7'd1) == w_limit) r_state <= S_FLUSH;
                        end else begin
                            r_pend_v <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_idx  <= 6'(r_pick_idx);
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `GBN_ASSERT_NEXT(a_start_home, w_start, (r_state == S_RUN) && (r_pos == PW'(MAX_BOXES)), "selection did not start from ring home")
    `GBN_ASSERT_NOW(a_flush_pending, r_state == S_FLUSH, r_pend_v, "final pick missing in flush")
    `GBN_ASSERT_NOW(a_idle_clean, r_state == S_IDLE, !r_pend_v, "pick left pending while idle")
    `GBN_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(MAX_BOXES), "load count beyond storage")

endmodule

`default_nettype wire
